// File: rtl/rnk_pkg.sv
// Shared constants and types for the rank normalizer.
// Used by rnk_cell, rank_normalizer and rnk_checker; depends on nothing.

package rnk_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int VALUE_W      = 32;
    localparam int RANK_W       = 6;
    localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);

    localparam logic [VALUE_W-1:0] SIGN_FLIP = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] key;
        logic [RANK_W-1:0]  cnt;
    } tok_t;

endpackage

// File: rtl/rnk_cell.sv
// One compare cell of the rank chain: holds a stored key and its running rank.
// Depends on rnk_pkg for the token type and widths.

module rnk_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rnk_pkg::tok_t         tok_in,
    output rnk_pkg::tok_t         tok_out,
    input  logic                  shift,
    input  logic                  occ_in,
    input  logic [rnk_pkg::RANK_W-1:0] rank_in,
    output logic                  occ,
    output logic [rnk_pkg::RANK_W-1:0] rank
);
    import rnk_pkg::*;

    logic               occ_reg;
    logic               occ_next;
    logic [VALUE_W-1:0] key_reg;
    logic [VALUE_W-1:0] key_next;
    logic [RANK_W-1:0]  rank_reg;
    logic [RANK_W-1:0]  rank_next;
    logic               tok_valid_reg;
    logic [VALUE_W-1:0] tok_key_reg;
    logic [RANK_W-1:0]  tok_cnt_reg;
    tok_t               tok_next;

    always_comb
    begin
        occ_next  = occ_reg;
        key_next  = key_reg;
        rank_next = rank_reg;
        tok_next  = tok_in;
        tok_next.valid = 1'b0;
        if (shift)
        begin
            occ_next  = occ_in;
            rank_next = rank_in;
        end
        else if (tok_in.valid)
        begin
            if (occ_reg)
            begin
                tok_next.valid = 1'b1;
                if (key_reg < tok_in.key)
                begin
                    tok_next.cnt = tok_in.cnt + RANK_W'(1);
                end
                else if (tok_in.key < key_reg)
                begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end
            else
            begin
                occ_next  = 1'b1;
                key_next  = tok_in.key;
                rank_next = tok_in.cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            tok_valid_reg <= tok_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        rank_reg    <= rank_next;
        tok_key_reg <= tok_next.key;
        tok_cnt_reg <= tok_next.cnt;
    end

    assign tok_out = '{valid: tok_valid_reg, key: tok_key_reg, cnt: tok_cnt_reg};
    assign occ     = occ_reg;
    assign rank    = rank_reg;

endmodule

// File: rtl/rank_normalizer.sv
// Top level of the rank normalizer: input control, the chain of compare cells
// and the result sequencer. Depends on rnk_pkg and rnk_cell.
//
// The input channel (in_valid, in_stall, value, last) takes one signed value
// per transfer; the transfer marked last closes the list. Each value enters
// the chain as a token that walks one cell per cycle, counting the stored
// values below it and bumping the rank of stored values above it, until it
// settles in the first free cell. Up to MAX_ELEMENTS values are kept; further
// values are dropped and set overflow on every result of that list.
// After the last transfer the input stalls until every result of the list has
// been given: once all tokens have settled, the output channel
// (out_valid, out_stall, rank, end_of_list, overflow) gives one rank per
// stored value in input order, one per cycle while out_stall is low, as the
// chain shifts toward its head. While out_stall is high the chain holds and
// the result stays unchanged. Reset empties the chain and returns the block
// to taking input.

module rank_normalizer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rnk_pkg::VALUE_W-1:0] value,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rnk_pkg::RANK_W-1:0]  rank,
    output logic                        end_of_list,
    output logic                        overflow
);
    import rnk_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                flag_reg;
    logic                flag_next;
    logic                entry_valid_reg;
    logic                entry_valid_next;
    logic [VALUE_W-1:0]  entry_key_reg;

    tok_t                tok [MAX_ELEMENTS+1];
    logic [MAX_ELEMENTS:0] tok_busy;
    logic [MAX_ELEMENTS:0] occ_chain;
    logic [RANK_W-1:0]   rank_chain [MAX_ELEMENTS+1];

    logic                in_xfer;
    logic                out_xfer;
    logic                has_room;
    logic                shift;

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_EMIT);
    assign out_xfer  = out_valid && !out_stall;
    assign shift     = out_xfer;
    assign has_room  = (count_reg < COUNT_W'(MAX_ELEMENTS));

    assign tok[0].valid = entry_valid_reg;
    assign tok[0].key   = entry_key_reg;
    assign tok[0].cnt   = '0;

    assign occ_chain[MAX_ELEMENTS]  = 1'b0;
    assign rank_chain[MAX_ELEMENTS] = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_ELEMENTS; k++)
        begin : g_cell
            rnk_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok[k]),
                .tok_out (tok[k+1]),
                .shift   (shift),
                .occ_in  (occ_chain[k+1]),
                .rank_in (rank_chain[k+1]),
                .occ     (occ_chain[k]),
                .rank    (rank_chain[k])
            );
        end
        for (k = 0; k <= MAX_ELEMENTS; k++)
        begin : g_busy
            assign tok_busy[k] = tok[k].valid;
        end
    endgenerate

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        flag_next        = flag_reg;
        entry_valid_next = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (has_room)
                    begin
                        entry_valid_next = 1'b1;
                        count_next       = count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        flag_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!(|tok_busy))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    count_next = count_reg - COUNT_W'(1);
                    if (count_reg == COUNT_W'(1))
                    begin
                        flag_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            count_reg       <= '0;
            flag_reg        <= 1'b0;
            entry_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            flag_reg        <= flag_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            entry_key_reg <= value ^ SIGN_FLIP;
        end
    end

    assign rank        = rank_chain[0];
    assign end_of_list = (count_reg == COUNT_W'(1));
    assign overflow    = flag_reg;

endmodule

// File: rtl/rnk_checker.sv
// Port-level checks for the rank normalizer, attached by the bind below.
// Depends on rnk_pkg for field widths and on the rank_normalizer ports.

module rnk_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        last,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [rnk_pkg::RANK_W-1:0]  rank,
    input logic                        end_of_list,
    input logic                        overflow
);
    import rnk_pkg::*;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rank) &&
        $stable(end_of_list) && $stable(overflow))
        else $error("Stalled result changed.");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("Input accepted after the closing transfer.");

    a_end_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && end_of_list |=> !out_valid)
        else $error("Result shown after the end of the list.");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("Input taken while results are pending.");

endmodule

bind rank_normalizer rnk_checker u_rnk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rank        (rank),
    .end_of_list (end_of_list),
    .overflow    (overflow)
);

// File: tb/tb_rank_normalizer.sv
// Self-checking testbench for rank_normalizer: random lists of signed values with random idling.
// A scoreboard class predicts the rank of every value.
// Depends on rnk_pkg and the RTL of rank_normalizer.
`timescale 1ns / 100ps

module tb_rank_normalizer;
    import rnk_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = MAX_ELEMENTS + 16;
    localparam int RANDOM_ITEMS   = 100;

    typedef struct {
        logic [RANK_W-1:0] rank;
        logic              end_of_list;
        logic              overflow;
    } rank_result_t;

    class rank_scoreboard;
        logic signed [VALUE_W-1:0] list_values[$];
        bit                        values_dropped;
        rank_result_t              expected_ranks[$];
        int                        errors;

        function void note_input(logic [VALUE_W-1:0] v, logic l);
            rank_result_t r;
            int           smaller;
            if (list_values.size() < MAX_ELEMENTS)
                list_values.push_back(v);
            else
                values_dropped = 1'b1;
            if (l)
            begin
                foreach (list_values[i])
                begin
                    smaller = 0;
                    foreach (list_values[j])
                        if (list_values[j] < list_values[i])
                            smaller++;
                    r.rank        = smaller[RANK_W-1:0];
                    r.end_of_list = (i == list_values.size() - 1);
                    r.overflow    = values_dropped;
                    expected_ranks.push_back(r);
                end
                list_values.delete();
                values_dropped = 1'b0;
            end
        endfunction

        function void check_result(logic [RANK_W-1:0] rank, logic eol, logic ovf);
            rank_result_t e;
            if (expected_ranks.size() == 0)
            begin
                $display("%0t: unexpected result rank %0d end_of_list %0b overflow %0b",
                         $time, rank, eol, ovf);
                errors++;
                return;
            end
            e = expected_ranks.pop_front();
            if (rank !== e.rank)
            begin
                $display("%0t: rank expected %0d, actual %0d", $time, e.rank, rank);
                errors++;
            end
            if (eol !== e.end_of_list)
            begin
                $display("%0t: end_of_list expected %0b, actual %0b", $time, e.end_of_list, eol);
                errors++;
            end
            if (ovf !== e.overflow)
            begin
                $display("%0t: overflow expected %0b, actual %0b", $time, e.overflow, ovf);
                errors++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [VALUE_W-1:0] value     = '0;
    logic               last      = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [RANK_W-1:0]  rank;
    logic               end_of_list;
    logic               overflow;

    rank_scoreboard sb;
    bit             idling_on    = 1'b1;
    bit             hold_request = 1'b0;
    int             items_sent   = 0;
    int             quiet_cycles = 0;

    always #5 clk = ~clk;

    rank_normalizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rank        (rank),
        .end_of_list (end_of_list),
        .overflow    (overflow)
    );

    task automatic send_item(input logic [VALUE_W-1:0] v, input logic l);
        while (idling_on && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(v, l);
        items_sent++;
    endtask

    task automatic send_list(input int len);
        logic [VALUE_W-1:0] v;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(6)) inside
                [0:1]:   v = $urandom;
                2:       v = $urandom_range(6) - 3;
                3:       v = 32'h7FFF_FFFF;
                4:       v = 32'h8000_0000;
                5:       v = '1;
                default: v = $urandom_range(3);
            endcase
            send_item(v, i == len - 1);
        end
    endtask

    // The receiver stalls at random, and for one long stretch on request.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(rank, end_of_list, overflow);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= idling_on && ($urandom_range(99) < 35);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int directed_items;
        int list_no;
        int pick;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(32'd0, 1'b1);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'd0, 1'b0);
        send_item(32'd1, 1'b0);
        send_item(32'd1, 1'b0);
        send_item(32'h8000_0000, 1'b1);
        for (int i = 0; i < 3; i++)
            send_item(32'hDEAD_BEEF, i == 2);
        for (int i = 0; i < 5; i++)
            send_item(32'(20 - 10 * i), i == 4);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'd1, 1'b1);

        // A full store, then an overflowing list whose final three values are dropped while the
        // receiver holds off and the next lists keep arriving.
        send_list(MAX_ELEMENTS);
        idling_on    = 1'b0;
        hold_request = 1'b1;
        send_list(MAX_ELEMENTS + 3);
        idling_on = 1'b1;
        directed_items = items_sent;

        list_no = 0;
        while (items_sent < directed_items + RANDOM_ITEMS)
        begin
            idling_on = !(list_no >= 2 && list_no < 6);
            pick = $urandom_range(99);
            if (pick < 85)
                send_list($urandom_range(1, 12));
            else if (pick < 95)
                send_list($urandom_range(13, 40));
            else
                send_list($urandom_range(MAX_ELEMENTS - 2, MAX_ELEMENTS + 2));
            list_no++;
        end
        in_valid <= 1'b0;
        idling_on = 1'b1;

        while (sb.expected_ranks.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
